### design/priority_failover_selector_macros.svh
// Assertion macros for the priority failover selector checker.
`ifndef PRIORITY_FAILOVER_SELECTOR_MACROS_SVH
`define PRIORITY_FAILOVER_SELECTOR_MACROS_SVH

// Same-cycle implication, sampled on clk, off while in reset.
`define PFS_ASSERT_IMP(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("pfs assertion failed");

// Next-cycle implication, sampled on clk, off while in reset.
`define PFS_ASSERT_NXT(label, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("pfs assertion failed");

`endif

### design/pfs_pkg.sv
// Types and constants shared by the priority failover selector files.
`timescale 1ns / 1ps
`default_nettype none

package pfs_pkg;

  // actions
  localparam logic [1:0] ACT_REPORT = 2'd0;
  localparam logic [1:0] ACT_TICK   = 2'd1;
  localparam logic [1:0] ACT_REEVAL = 2'd2;

  // link states
  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_CONN  = 2'd1;
  localparam logic [1:0] ST_READY = 2'd2;
  localparam logic [1:0] ST_TF    = 2'd3;

  // choice reasons
  localparam logic [2:0] RSN_READY    = 3'd0;
  localparam logic [2:0] RSN_FAILOVER = 3'd1;
  localparam logic [2:0] RSN_CONN     = 3'd2;
  localparam logic [2:0] RSN_NONE     = 3'd3;
  localparam logic [2:0] RSN_EMPTY    = 3'd4;

  // configuration register indexes
  localparam logic [1:0] CFG_NUM_PRIO  = 2'd0;
  localparam logic [1:0] CFG_FAILOVER  = 2'd1;
  localparam logic [1:0] CFG_RETENTION = 2'd2;

  localparam int CFG_DW = 20;

  localparam logic [15:0] FAILOVER_RESET  = 16'd10000;
  localparam logic [19:0] RETENTION_RESET = 20'd900000;

  typedef struct packed {
    logic [1:0] action;
    logic [2:0] slot_index;
    logic [1:0] new_state;
  } pfs_in_t;

  typedef struct packed {
    logic [2:0] chosen_slot;
    logic [1:0] chosen_state;
    logic [2:0] choice_reason;
  } pfs_out_t;

  typedef struct packed {
    logic        present;
    logic [1:0]  link;
    logic        seen_good;
    logic        fo_armed;
    logic [15:0] fo_left;
    logic        ret_armed;
    logic [19:0] ret_left;
  } pfs_slot_t;

  localparam pfs_slot_t SLOT_CLEAR = '{
    present:   1'b0,
    link:      ST_CONN,
    seen_good: 1'b1,
    fo_armed:  1'b0,
    fo_left:   16'd0,
    ret_armed: 1'b0,
    ret_left:  20'd0
  };

endpackage

`default_nettype wire

### design/priority_failover_selector.sv
// Priority failover selector: slot table, event walker and selection sequencer.
//
//   channel | ports                          | flow
//   --------+--------------------------------+---------------------------------
//   in      | in_valid, in_stall, in_data    | event item (report, tick, re-eval)
//   out     | out_valid, out_stall, out_data | one selection result per item
//   cfg     | cfg_we, cfg_index, cfg_wdata   | register writes, no read-back
//
// One slot is visited per cycle by a single read/update port on the slot table.
// Steps per item: accept, event walk (report visits one slot, tick or re-eval all
// MAX_SLOTS slots, else none), selection walk (up to 2*n slots, n = list length), emit.
// Reset is synchronous; it clears the slot table and the sequencer.
// A result waits in the output register while out_stall holds; the next item can
// be taken meanwhile, and its emit waits until the register is free.
`timescale 1ns / 1ps
`default_nettype none

module priority_failover_selector import pfs_pkg::*; #(
  parameter int MAX_SLOTS = 8
) (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_stall,
  input  wire pfs_in_t           in_data,
  output logic                   out_valid,
  input  wire logic              out_stall,
  output pfs_out_t               out_data,
  input  wire logic              cfg_we,
  input  wire logic [1:0]        cfg_index,
  input  wire logic [CFG_DW-1:0] cfg_wdata
);

  localparam int IW = (MAX_SLOTS > 1) ? $clog2(MAX_SLOTS) : 1;
  localparam int CW = $clog2(MAX_SLOTS + 1);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_REPORT = 3'd1;
  localparam logic [2:0] S_TICK   = 3'd2;
  localparam logic [2:0] S_REEVAL = 3'd3;
  localparam logic [2:0] S_SEL1   = 3'd4;
  localparam logic [2:0] S_RETIRE = 3'd5;
  localparam logic [2:0] S_SEL2   = 3'd6;
  localparam logic [2:0] S_EMIT   = 3'd7;

  logic [2:0]    state_r, state_nxt;
  logic [CW-1:0] ptr_r, ptr_nxt;
  pfs_in_t       item_r;
  logic [3:0]    num_prio_r;
  logic [15:0]   fo_ticks_r;
  logic [19:0]   ret_ticks_r;
  pfs_slot_t     slot_r [MAX_SLOTS];
  pfs_out_t      res_r, res_nxt;
  logic          out_valid_r;
  pfs_out_t      out_data_r;

  logic [CW-1:0] n_w;
  logic [CW-1:0] last_w;
  logic [IW-1:0] rd_idx;
  logic [2:0]    ptr_slot;
  logic          rep_ok;
  logic          ptr_at_last;
  logic          ptr_at_end;
  pfs_slot_t     cur;
  pfs_slot_t     wr_val;
  logic          wr_en;
  logic          emit_go;
  logic [15:0]   fo_dec;
  logic [19:0]   ret_dec;
  logic          fo_exp;
  logic          ret_exp;

  assign n_w    = (32'(num_prio_r) > MAX_SLOTS) ? CW'(MAX_SLOTS) : CW'(num_prio_r);
  assign last_w = n_w - CW'(1);
  assign rep_ok = 32'(item_r.slot_index) < MAX_SLOTS;
  assign rd_idx = (state_r == S_REPORT) ? IW'(item_r.slot_index) : ptr_r[IW-1:0];
  assign ptr_slot    = 3'(ptr_r[IW-1:0]);
  assign ptr_at_last = (ptr_r == last_w);
  assign ptr_at_end  = (ptr_r == CW'(MAX_SLOTS - 1));
  assign cur = slot_r[rd_idx];

  // shared countdown unit on the visited slot
  assign fo_dec  = cur.fo_left - 16'd1;
  assign ret_dec = cur.ret_left - 20'd1;
  assign fo_exp  = (cur.fo_left <= 16'd1);
  assign ret_exp = (cur.ret_left <= 20'd1);

  assign emit_go = (state_r == S_EMIT) && (!out_valid_r || !out_stall);

  always_comb begin
    state_nxt = state_r;
    ptr_nxt   = ptr_r;
    res_nxt   = res_r;
    wr_en     = 1'b0;
    wr_val    = cur;
    case (state_r)
      S_IDLE: begin
        ptr_nxt = '0;
        if (in_valid) begin
          case (in_data.action)
            ACT_REPORT: state_nxt = S_REPORT;
            ACT_TICK:   state_nxt = S_TICK;
            ACT_REEVAL: state_nxt = S_REEVAL;
            default:    state_nxt = S_SEL1;
          endcase
        end
      end
      S_REPORT: begin
        if (rep_ok && cur.present) begin
          wr_en       = 1'b1;
          wr_val.link = item_r.new_state;
          if (item_r.new_state == ST_CONN) begin
            if (cur.seen_good && !cur.fo_armed) begin
              wr_val.fo_armed = 1'b1;
              wr_val.fo_left  = fo_ticks_r;
            end
          end else begin
            wr_val.seen_good = (item_r.new_state != ST_TF);
            wr_val.fo_armed  = 1'b0;
            wr_val.fo_left   = 16'd0;
          end
        end
        ptr_nxt   = '0;
        state_nxt = S_SEL1;
      end
      S_TICK: begin
        if (cur.present) begin
          wr_en = 1'b1;
          if (cur.ret_armed && ret_exp) begin
            wr_val = SLOT_CLEAR;
          end else begin
            if (cur.ret_armed) wr_val.ret_left = ret_dec;
            if (cur.fo_armed && fo_exp) begin
              // failover expiry acts as a transient failure report
              wr_val.link      = ST_TF;
              wr_val.seen_good = 1'b0;
              wr_val.fo_armed  = 1'b0;
              wr_val.fo_left   = 16'd0;
            end else if (cur.fo_armed) begin
              wr_val.fo_left = fo_dec;
            end
          end
        end
        if (ptr_at_end) begin
          ptr_nxt   = '0;
          state_nxt = S_SEL1;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      S_REEVAL: begin
        if (ptr_r >= n_w && cur.present && !cur.ret_armed) begin
          wr_en            = 1'b1;
          wr_val.ret_armed = 1'b1;
          wr_val.ret_left  = ret_ticks_r;
        end
        if (ptr_at_end) begin
          ptr_nxt   = '0;
          state_nxt = S_SEL1;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      S_SEL1: begin
        if (n_w == '0) begin
          res_nxt   = '{chosen_slot: 3'd0, chosen_state: ST_TF, choice_reason: RSN_EMPTY};
          state_nxt = S_EMIT;
        end else if (!cur.present) begin
          // create the slot: connecting with its failover timer running
          wr_en           = 1'b1;
          wr_val          = SLOT_CLEAR;
          wr_val.present  = 1'b1;
          wr_val.fo_armed = 1'b1;
          wr_val.fo_left  = fo_ticks_r;
          res_nxt   = '{chosen_slot: ptr_slot, chosen_state: ST_CONN,
                        choice_reason: RSN_FAILOVER};
          state_nxt = S_EMIT;
        end else begin
          wr_en            = 1'b1;
          wr_val.ret_armed = 1'b0;
          wr_val.ret_left  = 20'd0;
          if (cur.link == ST_READY || cur.link == ST_IDLE) begin
            res_nxt = '{chosen_slot: ptr_slot, chosen_state: cur.link,
                        choice_reason: RSN_READY};
            if (ptr_at_last) begin
              state_nxt = S_EMIT;
            end else begin
              ptr_nxt   = ptr_r + CW'(1);
              state_nxt = S_RETIRE;
            end
          end else if (cur.fo_armed) begin
            res_nxt   = '{chosen_slot: ptr_slot, chosen_state: cur.link,
                          choice_reason: RSN_FAILOVER};
            state_nxt = S_EMIT;
          end else if (ptr_at_last) begin
            ptr_nxt   = '0;
            state_nxt = S_SEL2;
          end else begin
            ptr_nxt = ptr_r + CW'(1);
          end
        end
      end
      S_RETIRE: begin
        if (cur.present && !cur.ret_armed) begin
          wr_en            = 1'b1;
          wr_val.ret_armed = 1'b1;
          wr_val.ret_left  = ret_ticks_r;
        end
        if (ptr_at_last) begin
          state_nxt = S_EMIT;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      S_SEL2: begin
        if (cur.link == ST_CONN) begin
          res_nxt   = '{chosen_slot: ptr_slot, chosen_state: cur.link,
                        choice_reason: RSN_CONN};
          state_nxt = S_EMIT;
        end else if (ptr_at_last) begin
          res_nxt   = '{chosen_slot: ptr_slot, chosen_state: cur.link,
                        choice_reason: RSN_NONE};
          state_nxt = S_EMIT;
        end else begin
          ptr_nxt = ptr_r + CW'(1);
        end
      end
      S_EMIT: begin
        if (emit_go) state_nxt = S_IDLE;
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      ptr_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      ptr_r       <= ptr_nxt;
      out_valid_r <= emit_go || (out_valid_r && out_stall);
    end
  end

  always_ff @(posedge clk) begin
    res_r <= res_nxt;
    if (state_r == S_IDLE && in_valid) item_r <= in_data;
    if (emit_go) out_data_r <= res_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      num_prio_r  <= 4'd0;
      fo_ticks_r  <= FAILOVER_RESET;
      ret_ticks_r <= RETENTION_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        CFG_NUM_PRIO:  num_prio_r  <= cfg_wdata[3:0];
        CFG_FAILOVER:  fo_ticks_r  <= cfg_wdata[15:0];
        CFG_RETENTION: ret_ticks_r <= cfg_wdata[19:0];
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      for (int i = 0; i < MAX_SLOTS; i++) slot_r[i] <= SLOT_CLEAR;
    end else if (wr_en) begin
      slot_r[rd_idx] <= wr_val;
    end
  end

  assign in_stall  = (state_r != S_IDLE);
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

`default_nettype wire

### design/pfs_checker.sv
// Port-level checker for the priority failover selector, bound to the top level.
`timescale 1ns / 1ps
`default_nettype none
`include "priority_failover_selector_macros.svh"

module pfs_port_checker import pfs_pkg::*; (
  input wire logic     clk,
  input wire logic     rst_n,
  input wire logic     in_valid,
  input wire logic     in_stall,
  input wire pfs_in_t  in_data,
  input wire logic     out_valid,
  input wire logic     out_stall,
  input wire pfs_out_t out_data
);

  logic rsn_empty;
  logic rsn_ready;
  logic rsn_conn;
  logic empty_shape;
  logic ready_link;

  assign rsn_empty   = out_valid && (out_data.choice_reason == RSN_EMPTY);
  assign rsn_ready   = out_valid && (out_data.choice_reason == RSN_READY);
  assign rsn_conn    = out_valid && (out_data.choice_reason == RSN_FAILOVER ||
                                     out_data.choice_reason == RSN_CONN);
  assign empty_shape = (out_data.chosen_slot == 3'd0) && (out_data.chosen_state == ST_TF);
  assign ready_link  = (out_data.chosen_state == ST_READY) || (out_data.chosen_state == ST_IDLE);

  `PFS_ASSERT_NXT(a_out_hold, out_valid && out_stall, out_valid && $stable(out_data))

  // one item at a time: busy right after an accept
  `PFS_ASSERT_NXT(a_busy_after_accept, in_valid && !in_stall, in_stall)

  `PFS_ASSERT_IMP(a_empty_result, rsn_empty, empty_shape)

  `PFS_ASSERT_IMP(a_ready_state, rsn_ready, ready_link)

  // an armed failover timer only lives on a connecting slot
  `PFS_ASSERT_IMP(a_conn_state, rsn_conn, out_data.chosen_state == ST_CONN)

endmodule

bind priority_failover_selector pfs_port_checker u_pfs_port_checker (.*);

`default_nettype wire
